// ===== sv/hsfp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsfp_pkg
// shared types and constants for the stick frame parser
// ----------------------------------------------------------------------------
package hsfp_pkg;

    localparam int          KEPT_DATA_BYTES_DEF = 8;
    localparam int          AXIS_BYTES          = 8;
    localparam logic [15:0] CRC_POLY            = 16'h1021;
    localparam logic [15:0] CRC_INIT            = 16'hFFFF;
    localparam logic [7:0]  HEAD_RESET          = 8'h55;

    typedef enum logic [2:0] {
        PH_HEAD   = 3'd0,
        PH_ID     = 3'd1,
        PH_LEN    = 3'd2,
        PH_DATA   = 3'd3,
        PH_CRC_LO = 3'd4,
        PH_CRC_HI = 3'd5
    } t_phase;

    typedef struct packed {
        logic               valid;
        logic               frame_ok;
        logic signed [15:0] axis_x1;
        logic signed [15:0] axis_y1;
        logic signed [15:0] axis_y2;
        logic signed [15:0] axis_x2;
        logic [7:0]         stick_state;
    } t_result;

endpackage
`default_nettype wire

// ===== sv/hsfp_crc.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsfp_crc
// one-byte update of crc-16/ccitt-false, msb first
// ----------------------------------------------------------------------------
module hsfp_crc import hsfp_pkg::*; (
    input  wire logic [15:0] i_crc,
    input  wire logic [7:0]  i_byte,
    output logic      [15:0] o_crc
);

    always_comb begin
        logic [15:0] c;
        c = i_crc ^ {i_byte, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        o_crc = c;
    end

endmodule
`default_nettype wire

// ===== sv/hsfp_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsfp_parser
// frame state machine, data store, crc check and axis decode
// ----------------------------------------------------------------------------
module hsfp_parser import hsfp_pkg::*; #(
    parameter int KEPT_DATA_BYTES = KEPT_DATA_BYTES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [7:0] i_cfg_wr_data,
    output t_result         o_res
);

    localparam int IDX_W = (KEPT_DATA_BYTES > 1) ? $clog2(KEPT_DATA_BYTES) : 1;

    t_phase            r_phase, n_phase;
    logic [7:0]        r_head;
    logic [7:0]        r_len, n_len;
    logic [7:0]        r_cnt, n_cnt;
    logic [15:0]       r_crc, n_crc;
    logic [7:0]        r_rcv_lo, n_rcv_lo;
    logic [7:0]        r_store [KEPT_DATA_BYTES];
    logic [7:0]        r_last, n_last;
    logic [3:0][15:0]  r_axis, n_axis;
    logic [7:0]        r_stick, n_stick;

    logic              w_store_we;
    logic [15:0]       w_crc_in, w_crc_out;
    logic              w_ok;
    logic              w_done;

    assign w_crc_in = (r_phase == PH_ID || r_phase == PH_LEN || r_phase == PH_DATA)
                      ? r_crc : CRC_INIT;

    hsfp_crc u_crc (
        .i_crc  (w_crc_in),
        .i_byte (i_byte),
        .o_crc  (w_crc_out)
    );

    always_comb begin
        n_phase    = r_phase;
        n_len      = r_len;
        n_cnt      = r_cnt;
        n_crc      = r_crc;
        n_rcv_lo   = r_rcv_lo;
        n_last     = r_last;
        n_axis     = r_axis;
        n_stick    = r_stick;
        w_store_we = 1'b0;
        w_ok       = 1'b0;
        w_done     = 1'b0;
        case (r_phase)
            PH_ID: begin
                n_crc   = w_crc_out;
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                n_crc   = w_crc_out;
                n_len   = i_byte;
                n_cnt   = 8'd0;
                n_phase = (i_byte != 8'd0) ? PH_DATA : PH_CRC_LO;
            end
            PH_DATA: begin
                n_crc      = w_crc_out;
                w_store_we = (r_cnt < 8'(KEPT_DATA_BYTES));
                n_last     = i_byte;
                n_cnt      = r_cnt + 8'd1;
                if (n_cnt >= r_len) begin
                    n_phase = PH_CRC_LO;
                end
            end
            PH_CRC_LO: begin
                n_rcv_lo = i_byte;
                n_phase  = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                w_done  = 1'b1;
                w_ok    = ({i_byte, r_rcv_lo} == r_crc);
                n_phase = PH_HEAD;
                if (w_ok) begin
                    // negate each little-endian pair, 0x8000 wraps to itself
                    for (int k = 0; k < AXIS_BYTES / 2; k++) begin
                        n_axis[k] = 16'h0000 - {r_store[2*k+1], r_store[2*k]};
                    end
                    if (r_len != 8'd0) begin
                        n_stick = r_last;
                    end
                end
            end
            default: begin
                n_phase = PH_HEAD;
                if (i_byte == r_head) begin
                    n_crc   = w_crc_out;
                    n_phase = PH_ID;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEAD;
            r_head   <= HEAD_RESET;
            r_len    <= 8'd0;
            r_cnt    <= 8'd0;
            r_crc    <= CRC_INIT;
            r_rcv_lo <= 8'd0;
            r_last   <= 8'd0;
            r_axis   <= '0;
            r_stick  <= 8'd0;
            for (int j = 0; j < KEPT_DATA_BYTES; j++) begin
                r_store[j] <= 8'd0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_head <= i_cfg_wr_data;
            end
            if (i_valid) begin
                r_phase  <= n_phase;
                r_len    <= n_len;
                r_cnt    <= n_cnt;
                r_crc    <= n_crc;
                r_rcv_lo <= n_rcv_lo;
                r_last   <= n_last;
                r_axis   <= n_axis;
                r_stick  <= n_stick;
                if (w_store_we) begin
                    r_store[r_cnt[IDX_W-1:0]] <= i_byte;
                end
            end
        end
    end

    always_comb begin
        o_res.valid       = i_valid && w_done;
        o_res.frame_ok    = w_ok;
        o_res.axis_x1     = n_axis[0];
        o_res.axis_y1     = n_axis[1];
        o_res.axis_y2     = n_axis[2];
        o_res.axis_x2     = n_axis[3];
        o_res.stick_state = n_stick;
    end

endmodule
`default_nettype wire

// ===== sv/hall_stick_frame_parser_crc16.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hall_stick_frame_parser_crc16
// serial frame parser with crc-16 check and joystick axis decode
// ----------------------------------------------------------------------------
// a held input word is parsed once the result slot is free; a frame result
//   shows on o_res_valid right after the edge that parses the checksum high byte
// throughput: one word per cycle unless stalled, set by the one-pass crc update
// reset: synchronous active low; clears parser state, data store, axes,
//   and restores head byte 0x55; no clearing pass is needed
// ----------------------------------------------------------------------------
module hall_stick_frame_parser_crc16 import hsfp_pkg::*; #(
    parameter int KEPT_DATA_BYTES = KEPT_DATA_BYTES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // received byte channel
    input  wire logic               i_rx_valid,
    output logic                    o_rx_stall,
    input  wire logic [7:0]         i_rx_byte,
    // head byte register
    input  wire logic               i_cfg_wr_en,
    input  wire logic [7:0]         i_cfg_wr_data,
    // result channel
    output logic                    o_res_valid,
    input  wire logic               i_res_stall,
    output logic                    o_frame_ok,
    output logic signed [15:0]      o_axis_x1,
    output logic signed [15:0]      o_axis_y1,
    output logic signed [15:0]      o_axis_y2,
    output logic signed [15:0]      o_axis_x2,
    output logic [7:0]              o_stick_state
);

    // input register stage
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // result register stage
    logic       r_out_valid;
    t_result    r_out;

    t_result    w_res;
    logic       w_out_ready;
    logic       w_proc;
    logic       w_accept;

    // result slot is free when empty or being drained this cycle
    assign w_out_ready = !r_out_valid || !i_res_stall;
    // the held word is parsed only when its possible result has a place to go
    assign w_proc      = r_in_valid && w_out_ready;
    assign o_rx_stall  = r_in_valid && !w_out_ready;
    assign w_accept    = i_rx_valid && !o_rx_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    hsfp_parser #(
        .KEPT_DATA_BYTES (KEPT_DATA_BYTES)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_proc),
        .i_byte        (r_in_byte),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_res         (w_res)
    );

    // result register, loaded only from a completed frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res.valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_res_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.valid) begin
            r_out <= w_res;
        end
    end

    assign o_res_valid   = r_out_valid;
    assign o_frame_ok    = r_out.frame_ok;
    assign o_axis_x1     = r_out.axis_x1;
    assign o_axis_y1     = r_out.axis_y1;
    assign o_axis_y2     = r_out.axis_y2;
    assign o_axis_x2     = r_out.axis_x2;
    assign o_stick_state = r_out.stick_state;

`ifndef SYNTHESIS
    // stall is raised only while a word is held
    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_stall |-> r_in_valid)
        else $error("stall without held word");

    // a result comes only from a parsed word
    a_res_from_proc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.valid |-> w_proc)
        else $error("result without parsed word");

    // a new result never overwrites one still waiting
    a_res_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.valid |-> (!r_out_valid || !i_res_stall))
        else $error("result overwrote pending word");

    // a word held under stall is still there on the next cycle
    a_held_word_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_stall |=> r_in_valid && $stable(r_in_byte))
        else $error("held word lost");
`endif

endmodule
`default_nettype wire
